// ===== hw/rtl/sha256_pkg.sv =====
// SHA-256 package: word type, sequencer control struct, round constants,
// initial hash values and the sigma functions.
// No dependencies.
package sha256_pkg;

  typedef logic [31:0] word_t;

  // Control from the sequencer to the schedule window and the round unit
  typedef struct packed {
    logic push;   // shift a message or padding word into the block window
    logic start;  // load working variables from the hash words
    logic step;   // run one round and extend the schedule by one word
    logic add;    // fold working variables into the hash words
    logic init;   // restore the initial hash values
  } ctl_t;

  localparam word_t PAD_WORD = 32'h8000_0000;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [2:0] FULL_COUNT = 3'd4;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    unique case (i)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      3'd7: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    unique case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== hw/rtl/sha256_if.sv =====
// Valid/ready channel interfaces for the SHA-256 engine: message words in,
// digest words out. No dependencies.
interface sha256_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        end_of_message;

  modport source (output valid, message_word, valid_bytes, end_of_message,
                  input ready);
  modport sink (input valid, message_word, valid_bytes, end_of_message,
                output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;

  modport source (output valid, digest_word, digest_index, digest_last,
                  input ready);
  modport sink (input valid, digest_word, digest_index, digest_last,
                output ready);
endinterface

// ===== hw/rtl/sha256_sched.sv =====
// SHA-256 block window and message schedule: a 16-word shift line that
// collects the block and then extends it one word per round.
// Depends on sha256_pkg.
module sha256_sched (
  input  logic               clk,
  input  sha256_pkg::ctl_t   ctl,
  input  sha256_pkg::word_t  push_word,
  output sha256_pkg::word_t  w_t
);
  import sha256_pkg::*;

  word_t win [16];
  word_t w_new;

  // W[t+16] from the window positions t, t+1, t+9, t+14
  assign w_new = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
  assign w_t   = win[0];

  // Shift in either a loaded word or the next schedule word
  always_ff @(posedge clk) begin
    if (ctl.push || ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= ctl.push ? push_word : w_new;
    end
  end

endmodule

// ===== hw/rtl/sha256_round.sv =====
// SHA-256 round unit: working variables a..h, one compression round per
// step, and the eight hash words. Depends on sha256_pkg.
module sha256_round (
  input  logic                    clk,
  input  logic                    rst,
  input  sha256_pkg::ctl_t        ctl,
  input  logic [5:0]              round_idx,
  input  sha256_pkg::word_t       w_t,
  output sha256_pkg::word_t [7:0] hash
);
  import sha256_pkg::*;

  word_t v [8];
  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  always_comb begin
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1  = v[7] + big_sigma1(v[4]) + ch + round_k(round_idx) + w_t;
    t2  = big_sigma0(v[0]) + maj;
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= hash[i];
      end
    end else if (ctl.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  // Hash words: initial values after reset or a finished message
  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= init_hash(3'(i));
      end
    end else if (ctl.add) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash[i] + v[i];
      end
    end
  end

endmodule

// ===== hw/rtl/sha256_hash_engine.sv =====
// SHA-256 engine. A message word is taken while the 16-word block is
// filling; the request that completes a block is followed by 64 rounds
// and one hash update in the single round unit, during which no new
// message word is taken. The end request is followed by padding words up
// to the block end, one or two compressions, then eight digest words, one
// per cycle as the sink takes them; input is held off from the end request
// until the last digest word is taken, and the engine then starts fresh.
// Depends on sha256_pkg, sha256_if, sha256_sched and sha256_round.
module sha256_hash_engine (
  input logic                 clk,
  input logic                 rst,
  sha256_in_if.sink           msg,
  sha256_out_if.source        digest
);
  import sha256_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [3:0]  fill;
  logic [5:0]  round;
  logic [63:0] bit_len;
  logic        finishing;
  logic        extra_pad;
  logic        len_hi_sent;
  logic [2:0]  out_idx;

  logic        in_acc;
  logic        out_acc;
  logic [2:0]  cnt;
  word_t       first_word;
  word_t       push_word;
  word_t       w_t;
  word_t [7:0] hash;
  ctl_t        ctl;

  assign in_acc  = msg.valid && msg.ready;
  assign out_acc = digest.valid && digest.ready;

  // Byte count: anything but a short end count is a full word
  assign cnt = (msg.valid_bytes > FULL_COUNT || (!msg.end_of_message
               && msg.valid_bytes < FULL_COUNT)) ? FULL_COUNT : msg.valid_bytes;

  // Short final word: keep the valid bytes and place the pad byte behind them
  always_comb begin
    unique case (cnt)
      3'd0:    first_word = PAD_WORD;
      3'd1:    first_word = {msg.message_word[31:24], PAD_BYTE, 16'h0};
      3'd2:    first_word = {msg.message_word[31:16], PAD_BYTE, 8'h0};
      3'd3:    first_word = {msg.message_word[31:8], PAD_BYTE};
      default: first_word = msg.message_word;
    endcase
  end

  // Word pushed into the block window
  always_comb begin
    if (state == ST_IDLE) begin
      push_word = first_word;
    end else if (extra_pad) begin
      push_word = PAD_WORD;
    end else if (len_hi_sent) begin
      push_word = bit_len[31:0];
    end else if (fill == 4'd14) begin
      push_word = bit_len[63:32];
    end else begin
      push_word = '0;
    end
  end

  // Control to the datapath
  always_comb begin
    ctl.push  = in_acc || (state == ST_PAD);
    ctl.start = ctl.push && (fill == 4'd15);
    ctl.step  = (state == ST_COMP);
    ctl.add   = (state == ST_ADD);
    ctl.init  = out_acc && digest.digest_last;
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (ctl.start) state_next = ST_COMP;
          else if (msg.end_of_message) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (ctl.start) state_next = ST_COMP;
      end
      ST_COMP: begin
        if (round == 6'd63) state_next = ST_ADD;
      end
      ST_ADD: begin
        if (!finishing) state_next = ST_IDLE;
        else if (len_hi_sent) state_next = ST_EMIT;
        else state_next = ST_PAD;
      end
      ST_EMIT: begin
        if (ctl.init) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill        <= '0;
      round       <= '0;
      bit_len     <= '0;
      finishing   <= 1'b0;
      extra_pad   <= 1'b0;
      len_hi_sent <= 1'b0;
      out_idx     <= '0;
    end else begin
      state <= state_next;
      if (ctl.push) fill <= fill + 4'd1;
      if (ctl.start) round <= '0;
      else if (ctl.step) round <= round + 6'd1;

      // Message length and end-of-message bookkeeping
      if (in_acc) begin
        bit_len <= bit_len + {58'b0, cnt, 3'b000};
        if (msg.end_of_message) begin
          finishing <= 1'b1;
          extra_pad <= (cnt == FULL_COUNT);
        end
      end
      if (state == ST_PAD) begin
        if (extra_pad) extra_pad <= 1'b0;
        else if (!len_hi_sent && fill == 4'd14) len_hi_sent <= 1'b1;
      end

      // Digest output; the index wraps to zero on the last word
      if (out_acc) out_idx <= out_idx + 3'd1;
      if (ctl.init) begin
        fill        <= '0;
        bit_len     <= '0;
        finishing   <= 1'b0;
        len_hi_sent <= 1'b0;
      end
    end
  end

  assign msg.ready           = (state == ST_IDLE);
  assign digest.valid        = (state == ST_EMIT);
  assign digest.digest_word  = hash[out_idx];
  assign digest.digest_index = out_idx;
  assign digest.digest_last  = (out_idx == 3'd7);

  sha256_sched u_sched (
    .clk       (clk),
    .ctl       (ctl),
    .push_word (push_word),
    .w_t       (w_t)
  );

  sha256_round u_round (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .round_idx (round),
    .w_t       (w_t),
    .hash      (hash)
  );

endmodule

// ===== hw/rtl/sha256_checker.sv =====
// Port-level checks for the SHA-256 engine, bound to the top level.
// Depends on sha256_hash_engine ports only.
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic [2:0]  out_index,
  input logic        out_last
);

  // Last flag marks exactly the eighth word
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_index == 3'd7)))
    else $error("digest_last does not match digest_index");

  // No new request while a digest is being shown
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while digest pending");

  // An end request closes the input until the digest is out
  a_end_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_end) |=> !in_ready)
    else $error("input ready right after end of message");

  // Digest words come back to back in index order
  a_index_seq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && out_index == $past(out_index) + 3'd1))
    else $error("digest index sequence broken");

  // A stalled digest word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_word) && $stable(out_index)))
    else $error("digest word changed while stalled");

endmodule

bind sha256_hash_engine sha256_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (msg.valid),
  .in_ready  (msg.ready),
  .in_end    (msg.end_of_message),
  .out_valid (digest.valid),
  .out_ready (digest.ready),
  .out_word  (digest.digest_word),
  .out_index (digest.digest_index),
  .out_last  (digest.digest_last)
);

// ===== tb/sv/sha256_hash_engine_tb.sv =====
// Self-checking testbench for sha256_hash_engine: drives messages and checks
// each digest word against a SHA-256 predictor kept in a scoreboard class.
// Depends on sha256_pkg, sha256_if and the engine RTL.
module sha256_hash_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sha256_pkg::*;

  localparam int unsigned REQUEST_TARGET = 370;
  localparam int unsigned HOLD_AT        = 120;  // request count that arms the long stall
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned QUIET_AT       = 300;  // no idling after this many requests
  localparam int unsigned STALL_LIMIT    = 3000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  localparam word_t PAD_BIT = 32'h8000_0000;

  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_item_t;

  // Running SHA-256 state and the queue of digest words still owed
  class digest_tracker;
    word_t          hash_state [8];
    word_t          window [16];
    int unsigned    fill;
    bit [63:0]      bit_count;
    digest_item_t   expected_q [$];
    int unsigned    mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      foreach (hash_state[i]) hash_state[i] = H_INIT[i];
      fill = 0;
      bit_count = '0;
    endfunction

    function word_t rotr(word_t x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // 64 rounds over the current window, folded into the hash state
    function void run_rounds();
      word_t sched [64];
      word_t a, b, c, d, e, f, g, h;
      word_t t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) sched[i] = window[i];
      for (int i = 16; i < 64; i++) begin
        s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
        s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
        sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
      end
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int i = 0; i < 64; i++) begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + K_TABLE[i] + sched[i];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function void absorb(word_t x);
      window[fill] = x;
      fill = (fill + 1) & 15;
      if (fill == 0) run_rounds();
    endfunction

    // Accepted request: update the state, queue eight words on end of message
    function void note_request(word_t word, bit [2:0] vb, bit eom);
      int unsigned  n;
      word_t        keep;
      digest_item_t item;
      n = vb;
      // short counts mid-message and counts above four mean a full word
      if (n > 4 || (!eom && n < 4)) n = 4;
      bit_count += 64'(n * 8);
      if (!eom) begin
        absorb(word);
        return;
      end
      if (n == 4) begin
        absorb(word);
        absorb(PAD_BIT);
      end else begin
        keep = (n == 0) ? '0 : (32'hffff_ffff << (32 - 8 * n));
        absorb((word & keep) | (32'h80 << (24 - 8 * n)));
      end
      // no room for the length: close this block and pad a fresh one
      if (fill > 14) begin
        window[15] = '0;
        run_rounds();
        fill = 0;
      end
      for (int i = fill; i < 14; i++) window[i] = '0;
      window[14] = bit_count[63:32];
      window[15] = bit_count[31:0];
      run_rounds();
      for (int i = 0; i < 8; i++) begin
        item.word  = hash_state[i];
        item.index = 3'(i);
        item.last  = (i == 7);
        expected_q.push_back(item);
      end
      restart();
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] digest mismatch: %s", $realtime, what);
    endfunction

    // Accepted digest word against the oldest owed word
    function void check_digest(word_t word, logic [2:0] idx, logic last);
      digest_item_t exp;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected word %h idx %0d last %0b", word, idx, last));
        return;
      end
      exp = expected_q.pop_front();
      if (word !== exp.word || idx !== exp.index || last !== exp.last)
        flag($sformatf("exp word %h idx %0d last %0b, got word %h idx %0d last %0b",
                       exp.word, exp.index, exp.last, word, idx, last));
    endfunction
  endclass

  logic clk;
  logic rst;

  sha256_in_if  msg_ch ();
  sha256_out_if dig_ch ();

  sha256_hash_engine dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (dig_ch)
  );

  digest_tracker tracker;
  int unsigned   sent_count;
  int unsigned   idle_cycles;
  int unsigned   stall_left;
  bit            gaps_on;
  bit            stalls_on;
  bit            hold_request;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Drive one request at the falling edge, wait for the handshake
  task automatic send_request(word_t word, bit [2:0] vb, bit eom);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      msg_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    msg_ch.valid          <= 1'b1;
    msg_ch.message_word   <= word;
    msg_ch.valid_bytes    <= vb;
    msg_ch.end_of_message <= eom;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    tracker.note_request(word, vb, eom);
    sent_count++;
    if (sent_count == HOLD_AT) hold_request = 1'b1;
    if (sent_count == QUIET_AT) begin
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
    end
    @(negedge clk);
  endtask

  // Random message; lengths cluster around the padding boundaries
  task automatic send_random_message();
    int unsigned len;
    int unsigned pick;
    bit [2:0]    vb;
    pick = $urandom_range(0, 9);
    if (pick < 4)
      len = $urandom_range(1, 12);
    else if (pick < 8)
      len = 13 + $urandom_range(0, 4) + 16 * $urandom_range(0, 1);
    else
      len = $urandom_range(18, 48);
    for (int i = 1; i < len; i++) begin
      vb = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      send_request($urandom, vb, 1'b0);
    end
    send_request($urandom, 3'($urandom_range(0, 7)), 1'b1);
  endtask

  // Digest receiver: short random stalls plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      dig_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      dig_ch.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      stall_left = HOLD_CYCLES - 1;
      dig_ch.ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      dig_ch.ready <= 1'b0;
    end else begin
      dig_ch.ready <= 1'b1;
    end
  end

  // Digest checker
  always @(posedge clk) begin
    if (!rst && dig_ch.valid && dig_ch.ready)
      tracker.check_digest(dig_ch.digest_word, dig_ch.digest_index, dig_ch.digest_last);
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst                   = 1'b1;
    msg_ch.valid          = 1'b0;
    msg_ch.message_word   = '0;
    msg_ch.valid_bytes    = '0;
    msg_ch.end_of_message = 1'b0;
    dig_ch.ready          = 1'b0;
    sent_count   = 0;
    idle_cycles  = 0;
    stall_left   = 0;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    hold_request = 1'b0;
    tracker = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty message, junk in the ignored bytes
    send_request($urandom, 3'd0, 1'b1);
    // "abc" with a nonzero trailing byte that must be dropped
    send_request(32'h616263ff, 3'd3, 1'b1);
    // field extremes with end counts four, one, two and three
    send_request(32'hffff_ffff, 3'd4, 1'b1);
    send_request(32'h0000_0000, 3'd1, 1'b1);
    send_request(32'hffff_ffff, 3'd2, 1'b1);
    send_request(32'h0000_0000, 3'd3, 1'b1);
    // counts above four on the end request
    send_request(32'ha5a5_5a5a, 3'd5, 1'b1);
    // short and oversized counts mid-message count as full words
    send_request(32'h1234_5678, 3'd6, 1'b0);
    send_request(32'h9abc_def0, 3'd7, 1'b1);
    send_request(32'hffff_ffff, 3'd0, 1'b0);
    send_request(32'hdead_beef, 3'd3, 1'b1);
    send_request(32'h0000_0000, 3'd1, 1'b0);
    send_request(32'hffff_ffff, 3'd2, 1'b0);
    send_request(32'h8000_0001, 3'd0, 1'b1);

    while (sent_count < REQUEST_TARGET) send_random_message();
    msg_ch.valid <= 1'b0;

    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
